// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the observer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SMO_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define SMO_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SMO_ASSERT(label, clk, rst, prop)
`define SMO_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hdl/smo_pkg.sv =====
// Package for the sliding-mode position observer: payload types,
// register indexes and the CORDIC arctangent table. No dependencies.
package smo_pkg;

   typedef struct packed {
      logic signed [15:0] volt_alpha;
      logic signed [15:0] volt_beta;
      logic signed [15:0] amp_alpha;
      logic signed [15:0] amp_beta;
   } req_payload_type;

   typedef struct packed {
      logic        [15:0] rotor_angle;
      logic signed [23:0] rotor_speed;
      logic signed [15:0] emf_alpha_smooth;
      logic signed [15:0] emf_beta_smooth;
   } rsp_payload_type;

   // Register indexes.
   localparam logic [2:0] REG_RES  = 3'd0;
   localparam logic [2:0] REG_DTL  = 3'd1;
   localparam logic [2:0] REG_GAIN = 3'd2;
   localparam logic [2:0] REG_FC   = 3'd3;
   localparam logic [2:0] REG_RATE = 3'd4;

   localparam int CORDIC_MAX = 24;

   // Multiplier operation codes.
   localparam logic [1:0] MUL_SHR12_RND = 2'd0;
   localparam logic [1:0] MUL_SHR16_RND = 2'd1;
   localparam logic [1:0] MUL_RAW       = 2'd2;

   typedef struct packed {
      logic               start;
      logic [1:0]         op;
      logic signed [20:0] a;
      logic        [15:0] b;
   } mul_cmd_type;

   // Arctangent of 2^-i in 2^32 counts per turn.
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
            5'd6: r = 32'd10680350;   5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
            5'd20: r = 32'd652;       5'd21: r = 32'd326;
            5'd22: r = 32'd163;       5'd23: r = 32'd81;
            default: r = 32'd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== hdl/smo_mul.sv =====
// Shared signed-by-unsigned multiplier with registered result, rounded or raw by op code.
// Depends on smo_pkg.
module smo_mul (
   input  logic                clock,
   input  smo_pkg::mul_cmd_type cmd,
   output logic signed [33:0]  result
);
   import smo_pkg::*;

   logic signed [37:0] prod;
   logic signed [33:0] result_ff, result_in;

   // Exact product, then optional round-half-up shift.
   always_comb begin
      prod = 38'(cmd.a) * $signed({1'b0, cmd.b});
      case (cmd.op)
         MUL_SHR12_RND: result_in = 34'((prod + 38'sd2048) >>> 12);
         MUL_SHR16_RND: result_in = 34'((prod + 38'sd32768) >>> 16);
         default:       result_in = 34'(prod);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

// ===== hdl/smo_cordic.sv =====
// Iterative vectoring CORDIC: one rotation per cycle, angle in turns.
// Depends on smo_pkg and assert_macros.svh.
`include "assert_macros.svh"
module smo_cordic #(
   parameter int STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] xin,
   input  logic signed [15:0] yin,
   output logic               done,
   output logic        [15:0] angle
);
   import smo_pkg::*;

   localparam int N = (STEPS > CORDIC_MAX) ? CORDIC_MAX : STEPS;

   logic signed [26:0] x_ff, x_in, y_ff, y_in;
   logic        [31:0] acc_ff, acc_in;
   logic        [4:0]  i_ff, i_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic signed [26:0] xs, ys;

   always_comb begin
      x_in = x_ff; y_in = y_ff; acc_in = acc_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      if (start) begin
         i_in = 5'd0;
         if (xin == 16'sd0 && yin == 16'sd0) begin
            x_in = '0; y_in = '0; acc_in = '0;
            busy_in = 1'b0; done_in = 1'b1;
         end else if (xin < 0) begin
            x_in = -(27'(xin) <<< 8); y_in = -(27'(yin) <<< 8);
            acc_in = 32'h8000_0000; busy_in = 1'b1;
         end else begin
            x_in = 27'(xin) <<< 8; y_in = 27'(yin) <<< 8;
            acc_in = '0; busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // One micro-rotation towards the x axis.
         if (y_ff >= 0) begin
            x_in = x_ff + ys; y_in = y_ff - xs; acc_in = acc_ff + atan_turn(i_ff);
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs; acc_in = acc_ff - atan_turn(i_ff);
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(N - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; i_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; i_ff <= i_in;
      end
      x_ff <= x_in; y_ff <= y_in; acc_ff <= acc_in;
   end

   assign done  = done_ff;
   assign angle = 16'((acc_ff + 32'h8000) >> 16);

   `SMO_ASSERT(a_done_not_busy, clock, reset, done_ff |-> !busy_ff)
   `SMO_ASSERT(a_iter_bound, clock, reset, busy_ff |-> (i_ff < 5'(N)))
   `SMO_ASSERT(a_done_pulse, clock, reset, done_ff |=> !done_ff)
endmodule

// ===== hdl/sliding_mode_position_observer.sv =====
// Sliding-mode rotor position observer: a sequencer walks seven products
// through one shared 21x16 multiplier, alpha axis then beta axis, then starts
// the CORDIC, which runs one rotation per cycle, and forms the speed from the
// change in angle. The block is not ready while an item is in work or while a
// finished result waits in the output register; the next item is taken once
// that result has left.
// Depends on smo_pkg, smo_mul, smo_cordic and assert_macros.svh.
`include "assert_macros.svh"
module sliding_mode_position_observer #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  smo_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output smo_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_data
);
   import smo_pkg::*;

   // Sequencer states: each multiply has an issue and a use state.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DROP  = 4'd1;
   localparam logic [3:0] ST_DELTA = 4'd2;
   localparam logic [3:0] ST_EST   = 4'd3;
   localparam logic [3:0] ST_SMTH  = 4'd4;
   localparam logic [3:0] ST_SUPD  = 4'd5;
   localparam logic [3:0] ST_CORD  = 4'd6;
   localparam logic [3:0] ST_SPEED = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic        ax_ff, ax_in;      // 0 alpha, 1 beta
   logic        wait_ff, wait_in;  // wait for a product, or CORDIC start
   logic [15:0] res_ff, dtl_ff, fc_ff, rate_ff;
   logic [14:0] gain_ff;
   logic signed [15:0] est_ff [2], raw_ff [2], smooth_ff [2];
   logic signed [15:0] est_in, raw_in, smooth_in;
   logic [15:0] prev_ff;
   req_payload_type req_ff;
   rsp_payload_type out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   logic signed [33:0] tmp_ff, tmp_in;
   mul_cmd_type cmd;
   logic signed [33:0] mres;
   logic        cord_start, cord_done;
   logic [15:0] cord_angle;
   logic signed [15:0] volt, amp;
   logic signed [35:0] wide;

   smo_mul u_mul (.clock(clock), .cmd(cmd), .result(mres));

   smo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cord_start),
      .xin(smooth_ff[0]), .yin(smooth_ff[1]),
      .done(cord_done), .angle(cord_angle)
   );

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      if (v > 36'sd32767) return 16'sh7FFF;
      if (v < -36'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign csr_ready = 1'b1;
   assign volt = ax_ff ? req_ff.volt_beta : req_ff.volt_alpha;
   assign amp  = ax_ff ? req_ff.amp_beta  : req_ff.amp_alpha;

   // Sequencer over the shared multiplier and the CORDIC.
   always_comb begin
      state_in = state_ff; ax_in = ax_ff; wait_in = 1'b0; tmp_in = tmp_ff;
      est_in = est_ff[ax_ff]; raw_in = raw_ff[ax_ff]; smooth_in = smooth_ff[ax_ff];
      out_in = out_ff; out_valid_in = out_valid_ff;
      cmd = '{start: 1'b0, op: MUL_RAW, a: '0, b: '0};
      cord_start = 1'b0; wide = '0;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = ST_DROP; ax_in = 1'b0;
            end
         end
         ST_DROP: begin
            cmd = '{start: 1'b1, op: MUL_SHR12_RND, a: 21'(est_ff[ax_ff]), b: res_ff};
            state_in = ST_DELTA; wait_in = 1'b1;
         end
         ST_DELTA: begin
            // diff = v - drop - raw, at most 21 bits signed.
            wide = 36'(volt) - 36'(mres) - 36'(raw_ff[ax_ff]);
            cmd = '{start: 1'b1, op: MUL_SHR12_RND, a: wide[20:0], b: dtl_ff};
            state_in = ST_EST;
         end
         ST_EST: begin
            if (wait_ff) begin
               wait_in = 1'b0;
            end else begin
               wide = 36'(est_ff[ax_ff]) + 36'(mres);
               est_in = sat16(wide);
               raw_in = ((36'(amp) - 36'(est_in)) > 0) ? 16'(gain_ff) : -16'(gain_ff);
               state_in = ST_SMTH;
            end
         end
         ST_SMTH: begin
            wide = 36'(raw_ff[ax_ff]) - 36'(smooth_ff[ax_ff]);
            cmd = '{start: 1'b1, op: MUL_SHR16_RND, a: wide[20:0], b: fc_ff};
            state_in = ST_SUPD; wait_in = 1'b1;
         end
         ST_SUPD: begin
            if (wait_ff) begin
               wait_in = 1'b0;
            end else begin
               smooth_in = sat16(36'(smooth_ff[ax_ff]) + 36'(mres));
               if (ax_ff) begin
                  // The CORDIC starts once the beta EMF has been stored.
                  state_in = ST_CORD; wait_in = 1'b1;
               end else begin
                  ax_in = 1'b1; state_in = ST_DROP;
               end
            end
         end
         ST_CORD: begin
            if (wait_ff) begin
               cord_start = 1'b1;
            end else if (cord_done) begin
               wide = 36'(cord_angle) - 36'(prev_ff);
               cmd = '{start: 1'b1, op: MUL_RAW, a: 21'(signed'(wide[15:0])), b: rate_ff};
               tmp_in = 34'(cord_angle);
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: state_in = ST_OUT;
         ST_OUT: begin
            out_in.rotor_angle      = tmp_ff[15:0];
            out_in.rotor_speed      = (mres > 34'sd8388607) ? 24'sh7FFFFF :
                                      (mres < -34'sd8388608) ? 24'sh800000 : mres[23:0];
            out_in.emf_alpha_smooth = smooth_ff[0];
            out_in.emf_beta_smooth  = smooth_ff[1];
            out_valid_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ax_ff <= 1'b0; wait_ff <= 1'b0; out_valid_ff <= 1'b0;
         res_ff <= 16'd1024; dtl_ff <= 16'd4096; gain_ff <= 15'd4096;
         fc_ff <= 16'd6554; rate_ff <= 16'd20000;
         est_ff <= '{default: '0}; raw_ff <= '{default: '0};
         smooth_ff <= '{default: '0}; prev_ff <= '0;
      end else begin
         state_ff <= state_in; ax_ff <= ax_in; wait_ff <= wait_in;
         out_valid_ff <= out_valid_in;
         est_ff[ax_ff] <= est_in; raw_ff[ax_ff] <= raw_in; smooth_ff[ax_ff] <= smooth_in;
         if (state_ff == ST_CORD && !wait_ff && cord_done) prev_ff <= cord_angle;
         // Register writes; unknown indexes are ignored.
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_RES:  res_ff  <= csr_data;
               REG_DTL:  dtl_ff  <= csr_data;
               REG_GAIN: gain_ff <= csr_data[14:0];
               REG_FC:   fc_ff   <= csr_data;
               REG_RATE: rate_ff <= csr_data;
               default:  ;
            endcase
         end
      end
      if (req_valid && req_ready) req_ff <= req_payload;
      tmp_ff <= tmp_in;
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `SMO_ASSERT(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE) |-> !req_ready)
   `SMO_ASSERT(a_out_after_seq, clock, reset, $rose(out_valid_ff) |-> ($past(state_ff) == ST_OUT))
   `SMO_ASSERT(a_accept_starts, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_DROP))
endmodule
